// ----- src/fpq8_pkg.sv -----
package fpq8_pkg;

  // Width of the mode field
  localparam int MODE_W = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 4'd0,
    MODE_SUB    = 4'd1,
    MODE_MUL    = 4'd2,
    MODE_DIV    = 4'd3,
    MODE_GT     = 4'd4,
    MODE_LT     = 4'd5,
    MODE_GE     = 4'd6,
    MODE_LE     = 4'd7,
    MODE_EQ     = 4'd8,
    MODE_NE     = 4'd9,
    MODE_MIN    = 4'd10,
    MODE_MAX    = 4'd11,
    MODE_INC    = 4'd12,
    MODE_DEC    = 4'd13,
    MODE_TO_INT = 4'd14
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_SERIAL,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_DONE
  } state_t;

endpackage

// ----- src/fpq8_if.sv -----
interface fpq8_in_if
  import fpq8_pkg::*;
#(
  parameter int WORD_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic        [MODE_W-1:0]     mode;
  logic signed [WORD_WIDTH-1:0] operand_a;
  logic signed [WORD_WIDTH-1:0] operand_b;

  modport source (output valid, mode, operand_a, operand_b, input ready);
  modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface fpq8_out_if #(
  parameter int WORD_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [WORD_WIDTH-1:0] value;
  logic                         compare_true;
  logic                         divide_by_zero;

  modport source (output valid, value, compare_true, divide_by_zero, input ready);
  modport sink   (input valid, value, compare_true, divide_by_zero, output ready);
endinterface

// ----- src/fpq8_engine.sv -----
module fpq8_engine
  import fpq8_pkg::*;
#(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic        [MODE_W-1:0]     in_mode,
  input  logic signed [WORD_WIDTH-1:0] in_a,
  input  logic signed [WORD_WIDTH-1:0] in_b,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic        [WORD_WIDTH-1:0] res_value,
  output logic                         res_cmp,
  output logic                         res_dz
);

  localparam int W     = WORD_WIDTH;
  localparam int F     = FRAC_BITS;
  localparam int CNT_W = $clog2(W + F);
  localparam logic [CNT_W-1:0] LAST_W   = CNT_W'(W - 1);
  localparam logic [CNT_W-1:0] LAST_DIV = CNT_W'(W + F - 1);

  state_t           state_r, state_nxt;
  mode_t            mode_r, mode_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     a_r, a_nxt;
  logic [W-1:0]     b_r, b_nxt;
  logic [W-1:0]     acc_r, acc_nxt;
  logic [W-1:0]     q_r, q_nxt;
  logic             carry_r, carry_nxt;
  logic             lt_r, lt_nxt;
  logic             eq_r, eq_nxt;
  logic             neg_r, neg_nxt;
  logic [W-1:0]     val_r, val_nxt;
  logic             cmp_r, cmp_nxt;
  logic             dz_r, dz_nxt;

  // per-bit serial adder and compare
  logic             s_bbit;
  logic [1:0]       s_sum;
  // shift-add multiplier step
  logic [W:0]       m_sum;
  // restoring divider step
  logic [W:0]       d_shift;
  logic [W+1:0]     d_diff;
  logic             d_ge;
  // final sign fix
  logic [2*W-1:0]   prod;
  logic [W-1:0]     fin_src;
  logic             fin_cin;
  logic [W-1:0]     fin_val;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        case (mode_r)
          MODE_MUL: state_nxt = ST_MUL;
          MODE_DIV: state_nxt = (b_r == '0) ? ST_DONE : ST_DIV;
          MODE_ADD, MODE_SUB, MODE_INC, MODE_DEC, MODE_TO_INT,
          MODE_GT, MODE_LT, MODE_GE, MODE_LE, MODE_EQ, MODE_NE,
          MODE_MIN, MODE_MAX: state_nxt = ST_SERIAL;
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_SERIAL: begin
        if (cnt_r == LAST_W) state_nxt = ST_FIX;
      end
      ST_MUL: begin
        if (cnt_r == LAST_W) state_nxt = ST_FIX;
      end
      ST_DIV: begin
        if (cnt_r == LAST_DIV) state_nxt = ST_FIX;
      end
      ST_FIX: state_nxt = ST_DONE;
      ST_DONE: begin
        if (res_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    mode_nxt  = mode_r;
    cnt_nxt   = cnt_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    acc_nxt   = acc_r;
    q_nxt     = q_r;
    carry_nxt = carry_r;
    lt_nxt    = lt_r;
    eq_nxt    = eq_r;
    neg_nxt   = neg_r;
    val_nxt   = val_r;
    cmp_nxt   = cmp_r;
    dz_nxt    = dz_r;
    in_ready  = 1'b0;

    case (mode_r)
      MODE_ADD: s_bbit = b_r[0];
      MODE_SUB: s_bbit = ~b_r[0];
      MODE_DEC: s_bbit = 1'b1;
      default:  s_bbit = 1'b0;
    endcase
    s_sum = {1'b0, a_r[0]} + {1'b0, s_bbit} + {1'b0, carry_r};

    m_sum = {1'b0, acc_r} + (q_r[0] ? {1'b0, a_r} : '0);

    d_shift = {acc_r, a_r[W-1]};
    d_diff  = {1'b0, d_shift} - {2'b00, b_r};
    d_ge    = ~d_diff[W+1];

    // mul: bits [F+W-1:F] of the product, negated as ~x + (low bits zero)
    prod = {acc_r, q_r};
    if (mode_r == MODE_MUL) begin
      fin_src = prod[F +: W];
      fin_cin = neg_r & (prod[F-1:0] == '0);
    end else begin
      fin_src = q_r;
      fin_cin = neg_r;
    end
    fin_val = (fin_src ^ {W{neg_r}}) + W'(fin_cin);

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          mode_nxt = mode_t'(in_mode);
          a_nxt    = in_a;
          b_nxt    = in_b;
        end
      end
      ST_PREP: begin
        cnt_nxt = '0;
        val_nxt = '0;
        cmp_nxt = 1'b0;
        dz_nxt  = 1'b0;
        lt_nxt  = 1'b0;
        eq_nxt  = 1'b1;
        neg_nxt = a_r[W-1] ^ b_r[W-1];
        case (mode_r)
          MODE_SUB, MODE_INC: carry_nxt = 1'b1;
          MODE_TO_INT: begin
            a_nxt     = W'($signed(a_r) >>> F);
            carry_nxt = a_r[W-1] & (|a_r[F-1:0]);
          end
          MODE_MUL: begin
            a_nxt   = a_r[W-1] ? (~a_r + W'(1)) : a_r;
            q_nxt   = b_r[W-1] ? (~b_r + W'(1)) : b_r;
            acc_nxt = '0;
          end
          MODE_DIV: begin
            a_nxt   = a_r[W-1] ? (~a_r + W'(1)) : a_r;
            b_nxt   = b_r[W-1] ? (~b_r + W'(1)) : b_r;
            acc_nxt = '0;
            q_nxt   = '0;
            dz_nxt  = (b_r == '0);
          end
          default: carry_nxt = 1'b0;
        endcase
      end
      ST_SERIAL: begin
        acc_nxt   = {s_sum[0], acc_r[W-1:1]};
        carry_nxt = s_sum[1];
        a_nxt     = {a_r[0], a_r[W-1:1]};
        b_nxt     = {b_r[0], b_r[W-1:1]};
        if (a_r[0] != b_r[0]) begin
          eq_nxt = 1'b0;
          // sign bit decides in reverse
          lt_nxt = (cnt_r == LAST_W) ? a_r[0] : b_r[0];
        end
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      ST_MUL: begin
        acc_nxt = m_sum[W:1];
        q_nxt   = {m_sum[0], q_r[W-1:1]};
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      ST_DIV: begin
        a_nxt   = {a_r[W-2:0], 1'b0};
        acc_nxt = d_ge ? d_diff[W-1:0] : d_shift[W-1:0];
        q_nxt   = {q_r[W-2:0], d_ge};
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      ST_FIX: begin
        case (mode_r)
          MODE_MUL, MODE_DIV: val_nxt = fin_val;
          MODE_GT: cmp_nxt = ~lt_r & ~eq_r;
          MODE_LT: cmp_nxt = lt_r;
          MODE_GE: cmp_nxt = ~lt_r;
          MODE_LE: cmp_nxt = lt_r | eq_r;
          MODE_EQ: cmp_nxt = eq_r;
          MODE_NE: cmp_nxt = ~eq_r;
          MODE_MIN: val_nxt = lt_r ? a_r : b_r;
          MODE_MAX: val_nxt = (~lt_r & ~eq_r) ? a_r : b_r;
          default: val_nxt = acc_r;
        endcase
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  assign res_valid = (state_r == ST_DONE);
  assign res_value = val_r;
  assign res_cmp   = cmp_r;
  assign res_dz    = dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r  <= mode_nxt;
    cnt_r   <= cnt_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    acc_r   <= acc_nxt;
    q_r     <= q_nxt;
    carry_r <= carry_nxt;
    lt_r    <= lt_nxt;
    eq_r    <= eq_nxt;
    neg_r   <= neg_nxt;
    val_r   <= val_nxt;
    cmp_r   <= cmp_nxt;
    dz_r    <= dz_nxt;
  end

endmodule

// ----- src/fixed_point_q8_alu.sv -----
// Sequence: accept, prep, bit-serial phase, sign fix, done for add, sub, inc, dec, to_int,
//   compares, min, max and mul; div's serial phase also runs over the fraction bits (Q24.8
//   by default); divide by zero and the unused mode go from prep straight to done. The single
//   bit-serial engine (one bit, multiplier bit or quotient bit a cycle) takes one item at a time.
// Reset: rst_n is synchronous, active low; clears engine state and the output valid.
module fixed_point_q8_alu
  import fpq8_pkg::*;
#(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  fpq8_in_if.sink     in_ch,
  fpq8_out_if.source  out_ch
);

  // Engine side of the result handoff
  logic                  res_valid;
  logic                  res_ready;
  logic [WORD_WIDTH-1:0] res_value;
  logic                  res_cmp;
  logic                  res_dz;

  // Output register: holds a finished item so the engine can go back to
  // idle and take the next item while this one waits downstream.
  logic                  out_valid_r, out_valid_nxt;
  logic [WORD_WIDTH-1:0] out_value_r, out_value_nxt;
  logic                  out_cmp_r, out_cmp_nxt;
  logic                  out_dz_r, out_dz_nxt;

  // Engine: one item at a time.
  //   add/sub/inc/dec/to_int: LSB-first serial adder, one bit per cycle
  //   compares/min/max: LSB-first serial compare, operands rotate back intact
  //   mul: shift-add on magnitudes, one multiplier bit per cycle
  //   div: restoring division of |a|<<FRAC_BITS, one quotient bit per cycle
  // A final fix step applies the sign for mul and div (one W-bit add) and picks the result.
  fpq8_engine #(
    .WORD_WIDTH (WORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_mode   (in_ch.mode),
    .in_a      (in_ch.operand_a),
    .in_b      (in_ch.operand_b),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_value (res_value),
    .res_cmp   (res_cmp),
    .res_dz    (res_dz)
  );

  // Take a result whenever the output slot is empty or draining this cycle
  assign res_ready = ~out_valid_r | out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_cmp_nxt   = out_cmp_r;
    out_dz_nxt    = out_dz_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = res_value;
      out_cmp_nxt   = res_cmp;
      out_dz_nxt    = res_dz;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_cmp_r   <= out_cmp_nxt;
    out_dz_r    <= out_dz_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.value          = out_value_r;
  assign out_ch.compare_true   = out_cmp_r;
  assign out_ch.divide_by_zero = out_dz_r;

endmodule

// ----- tb/fpq8_result_checker.sv -----
`timescale 1ns / 100ps

module fpq8_result_checker
  import fpq8_pkg::*;
#(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  fpq8_in_if         in_mon,
  fpq8_out_if        out_mon,
  output int         mismatches,
  output int         pending
);

  typedef struct packed {
    logic [MODE_W-1:0]            mode;
    logic signed [WORD_WIDTH-1:0] a;
    logic signed [WORD_WIDTH-1:0] b;
    logic signed [WORD_WIDTH-1:0] value;
    logic                         compare_true;
    logic                         divide_by_zero;
  } alu_expect_t;

  alu_expect_t expected_results[$];
  int          error_count = 0;
  int          outstanding = 0;

  assign mismatches = error_count;
  assign pending    = outstanding;

  // Full-precision Q format arithmetic, wrapped to the word at the end.
  function automatic alu_expect_t predict_alu(input logic [MODE_W-1:0] mode,
                                              input logic signed [WORD_WIDTH-1:0] a,
                                              input logic signed [WORD_WIDTH-1:0] b);
    alu_expect_t r;
    longint      wa;
    longint      wb;
    longint      wide;
    wa = longint'(a);
    wb = longint'(b);
    r = '0;
    r.mode = mode;
    r.a = a;
    r.b = b;
    case (mode)
      MODE_ADD: r.value = a + b;
      MODE_SUB: r.value = a - b;
      MODE_MUL: begin
        wide = (wa * wb) >>> FRAC_BITS;   // floor, then wrap
        r.value = wide[WORD_WIDTH-1:0];
      end
      MODE_DIV: begin
        if (b == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          wide = (wa <<< FRAC_BITS) / wb;  // truncates toward zero
          r.value = wide[WORD_WIDTH-1:0];
        end
      end
      MODE_GT:     r.compare_true = (a > b);
      MODE_LT:     r.compare_true = (a < b);
      MODE_GE:     r.compare_true = (a >= b);
      MODE_LE:     r.compare_true = (a <= b);
      MODE_EQ:     r.compare_true = (a == b);
      MODE_NE:     r.compare_true = (a != b);
      MODE_MIN:    r.value = (a < b) ? a : b;
      MODE_MAX:    r.value = (b < a) ? a : b;
      MODE_INC:    r.value = a + 1;
      MODE_DEC:    r.value = a - 1;
      MODE_TO_INT: begin
        wide = wa / (longint'(1) <<< FRAC_BITS);
        r.value = wide[WORD_WIDTH-1:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_error(input string msg);
    $display("%0t ERROR %s", $time, msg);
    error_count++;
  endtask

  always @(posedge clk) begin : watch
    alu_expect_t due;
    if (rst_n) begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          report_error($sformatf("unexpected result value=%h cmp=%b dz=%b",
                                 out_mon.value, out_mon.compare_true,
                                 out_mon.divide_by_zero));
        end else begin
          due = expected_results.pop_front();
          if (out_mon.value !== due.value)
            report_error($sformatf("value mode=%0d a=%h b=%h got %h exp %h",
                                   due.mode, due.a, due.b, out_mon.value, due.value));
          if (out_mon.compare_true !== due.compare_true)
            report_error($sformatf("compare_true mode=%0d a=%h b=%h got %b exp %b",
                                   due.mode, due.a, due.b, out_mon.compare_true,
                                   due.compare_true));
          if (out_mon.divide_by_zero !== due.divide_by_zero)
            report_error($sformatf("divide_by_zero mode=%0d a=%h b=%h got %b exp %b",
                                   due.mode, due.a, due.b, out_mon.divide_by_zero,
                                   due.divide_by_zero));
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(predict_alu(in_mon.mode, in_mon.operand_a,
                                               in_mon.operand_b));
      outstanding = expected_results.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import fpq8_pkg::*;

  localparam int WORD_WIDTH = 32;
  localparam int FRAC_BITS  = 8;
  // Longest trip through the engine (divide) plus some slack
  localparam int DRAIN_CYCLES = WORD_WIDTH + FRAC_BITS + 3 + 20;
  // Receiver freeze long enough to back the engine up to the input
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int PHASES           = 8;
  localparam int ITEMS_PER_PHASE  = 106;

  // Mode code outside the enum; the block must answer it with all zeros
  localparam logic [MODE_W-1:0] MODE_UNUSED = 4'd15;

  localparam logic signed [WORD_WIDTH-1:0] MAX_RAW = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_WIDTH-1:0] MIN_RAW = 32'sh8000_0000;
  localparam logic signed [WORD_WIDTH-1:0] ONE_FX  = 32'sh0000_0100;  // 1.0 in Q24.8

  logic clk;
  logic rst_n;

  fpq8_in_if  #(.WORD_WIDTH(WORD_WIDTH)) in_ch ();
  fpq8_out_if #(.WORD_WIDTH(WORD_WIDTH)) out_ch ();

  int mismatches;
  int pending;

  // Idle shaping, changed per phase by the stimulus process
  int tx_max_gap   = 0;
  int rx_max_stall = 0;
  bit hold_output  = 1'b0;

  fixed_point_q8_alu #(
    .WORD_WIDTH(WORD_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  fpq8_result_checker #(
    .WORD_WIDTH(WORD_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the handshakes lock up
  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Offer one item. Valid stays up straight into the next item when gap is 0,
  // so it is never dropped and raised in the same step.
  task automatic send_item(input logic [MODE_W-1:0] mode,
                           input logic signed [WORD_WIDTH-1:0] a,
                           input logic signed [WORD_WIDTH-1:0] b,
                           input int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= mode;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Operand mix: mostly full-range words, some small values near zero so
  // products and quotients stay in range, and the corner words.
  function automatic logic signed [WORD_WIDTH-1:0] pick_operand();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: begin
        case ($urandom_range(0, 6))
          0: return 0;
          1: return 1;
          2: return -1;
          3: return ONE_FX;
          4: return -ONE_FX;
          5: return MAX_RAW;
          default: return MIN_RAW;
        endcase
      end
      1, 2: return $signed($urandom_range(0, 'h1FFFF)) - 'sh10000;
      3:    return $signed($urandom_range(0, 'hFFFFFF)) - 'sh800000;
      default: return $urandom();
    endcase
  endfunction

  // Receiver: per result, a random number of cycles with ready low, or the
  // long freeze when the stimulus asks for it.
  initial begin : rx_side
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        stall = LONG_HOLD_CYCLES;
        hold_output = 1'b0;
      end else begin
        stall = $urandom_range(0, rx_max_stall);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [MODE_W-1:0]            mode;
    logic signed [WORD_WIDTH-1:0] a;
    logic signed [WORD_WIDTH-1:0] b;

    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_ADD;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: wraps, rounding of signed products and quotients, divide by
    // zero, the most negative word over -1, ties, and the unused mode.
    send_item(MODE_ADD,    MAX_RAW,  1,        0);
    send_item(MODE_SUB,    MIN_RAW,  1,        0);
    send_item(MODE_SUB,    ONE_FX,   -ONE_FX,  0);
    send_item(MODE_MUL,    -1,       'sh80,    0);  // -1/256 * 0.5 floors to -1 lsb
    send_item(MODE_MUL,    MAX_RAW,  MAX_RAW,  0);
    send_item(MODE_MUL,    MIN_RAW,  MIN_RAW,  0);
    send_item(MODE_MUL,    -'sh180,  'sh200,   0);
    send_item(MODE_DIV,    ONE_FX,   0,        0);
    send_item(MODE_DIV,    MIN_RAW,  -1,       0);
    send_item(MODE_DIV,    -'sh300,  'sh200,   0);
    send_item(MODE_DIV,    -1,       3,        0);  // truncates toward zero
    send_item(MODE_DIV,    MAX_RAW,  MIN_RAW,  0);
    send_item(MODE_GT,     MIN_RAW,  MAX_RAW,  0);
    send_item(MODE_LT,     MIN_RAW,  MAX_RAW,  0);
    send_item(MODE_GE,     -5,       -5,       0);
    send_item(MODE_LE,     7,        7,        0);
    send_item(MODE_EQ,     MIN_RAW,  MIN_RAW,  0);
    send_item(MODE_NE,     MIN_RAW,  MAX_RAW,  0);
    send_item(MODE_MIN,    -ONE_FX,  ONE_FX,   0);
    send_item(MODE_MAX,    33,       33,       0);  // tie
    send_item(MODE_INC,    MAX_RAW,  MIN_RAW,  0);
    send_item(MODE_DEC,    MIN_RAW,  MAX_RAW,  0);
    send_item(MODE_TO_INT, -'sh180,  0,        0);  // -1.5 gives -1
    send_item(MODE_TO_INT, MIN_RAW,  -1,       0);
    send_item(MODE_UNUSED, MAX_RAW,  MAX_RAW,  0);

    // Sender waits for the engine to drain before random traffic starts
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (pending == 0);

    for (int p = 0; p < PHASES; p++) begin
      tx_max_gap   = (p % 3 == 0) ? 0 : 14;
      rx_max_stall = (p % 2 == 0) ? 14 : 0;
      if (p == 4) begin
        // Freeze the receiver while items keep coming back to back
        tx_max_gap  = 0;
        hold_output = 1'b1;
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        mode = ($urandom_range(0, 99) == 0) ? MODE_UNUSED
                                             : MODE_W'($urandom_range(0, 14));
        a = pick_operand();
        b = pick_operand();
        if ($urandom_range(0, 7) == 0)
          b = (mode == MODE_DIV) ? '0 : a;   // divide by zero, or a tie
        send_item(mode, a, b, $urandom_range(0, tx_max_gap));
      end
      @(negedge clk);
      in_ch.valid <= 1'b0;
      wait (pending == 0);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/fpq8_pkg.sv
src/fpq8_if.sv
src/fpq8_engine.sv
src/fixed_point_q8_alu.sv
tb/fpq8_result_checker.sv
tb/tb.sv
